>>> sv/pid_controller_clamped_core_assert.svh
// Assertion macros for the PID controller core.
`ifndef PID_CONTROLLER_CLAMPED_CORE_ASSERT_SVH
`define PID_CONTROLLER_CLAMPED_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PCC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define PCC_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define PCC_ASSERT(lbl, clk, rstn, prop, msg)
`define PCC_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

>>> sv/pcc_pkg.sv
// Shared constants, register codes and types for the PID controller core.
`timescale 1ns / 1ps
package pcc_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int ACC_BITS_DEF    = 32;

  localparam int GAIN_W     = 16;
  localparam int TIME_W     = 16;
  localparam int DRIVE_W    = 16;
  localparam int FRAC_BITS  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [GAIN_W-1:0]  GAIN_P_RST   = 16'd256;
  localparam logic [GAIN_W-1:0]  GAIN_I_RST   = 16'd0;
  localparam logic [GAIN_W-1:0]  GAIN_D_RST   = 16'd0;
  localparam int                 SETPOINT_RST = 2048;
  localparam logic [DRIVE_W-1:0] OUT_MIN_RST  = 16'h8000;
  localparam logic [DRIVE_W-1:0] OUT_MAX_RST  = 16'h7FFF;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX  = 3'd5;

  typedef struct packed {
    logic load;
    logic step;
  } pcc_ser_ctl_t;

endpackage

>>> sv/pcc_cfg_if.sv
// Configuration write channel.
`timescale 1ns / 1ps
interface pcc_cfg_if import pcc_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/pcc_in_if.sv
// Sample input channel.
`timescale 1ns / 1ps
interface pcc_in_if import pcc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic [TIME_W-1:0]      elapsed_ms;

  modport source (output valid, output sample, output elapsed_ms, input ready);
  modport sink (input valid, input sample, input elapsed_ms, output ready);
endinterface

>>> sv/pcc_out_if.sv
// Drive result channel.
`timescale 1ns / 1ps
interface pcc_out_if import pcc_pkg::*; ;
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;
  logic                      clamped_low;
  logic                      clamped_high;

  modport source (output valid, output drive, output clamped_low, output clamped_high,
                  input ready);
  modport sink (input valid, input drive, input clamped_low, input clamped_high,
                output ready);
endinterface

>>> sv/pcc_ser_mul.sv
// Bit-serial multiplier: signed multiplicand by unsigned 16-bit multiplier, one bit a cycle while stepping.
`timescale 1ns / 1ps
module pcc_ser_mul import pcc_pkg::*; #(
  parameter int W = SAMPLE_BITS_DEF + 1
) (
  input  logic                     clk,
  input  pcc_ser_ctl_t             ctl,
  input  logic signed [W-1:0]      mcand,
  input  logic [GAIN_W-1:0]        mplier,
  output logic signed [W+GAIN_W:0] prod
);

  logic [W-1:0]      mcand_r;
  logic [W:0]        hi_r;
  logic [GAIN_W-1:0] lo_r;
  logic [W:0]        add_nxt;

  assign add_nxt = hi_r + (lo_r[0] ? {mcand_r[W-1], mcand_r} : {(W+1){1'b0}});
  assign prod    = $signed({hi_r, lo_r});

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mcand_r <= mcand;
      hi_r    <= '0;
      lo_r    <= mplier;
    end else if (ctl.step) begin
      hi_r <= {add_nxt[W], add_nxt[W:1]};
      lo_r <= {add_nxt[0], lo_r[GAIN_W-1:1]};
    end
  end

endmodule

>>> sv/pcc_ser_div.sv
// Restoring divider, one quotient bit a cycle while stepping, unsigned operands.
`timescale 1ns / 1ps
module pcc_ser_div import pcc_pkg::*; #(
  parameter int N = SAMPLE_BITS_DEF + 1 + GAIN_W
) (
  input  logic              clk,
  input  pcc_ser_ctl_t      ctl,
  input  logic [N-1:0]      dividend,
  input  logic [TIME_W-1:0] divisor,
  output logic [N-1:0]      quot
);

  logic [TIME_W-1:0] rem_r;
  logic [TIME_W-1:0] dvsr_r;
  logic [N-1:0]      q_r;
  logic [TIME_W:0]   trial;
  logic [TIME_W:0]   diff;
  logic              ge;

  assign trial = {rem_r, q_r[N-1]};
  assign ge    = trial >= {1'b0, dvsr_r};
  assign diff  = trial - {1'b0, dvsr_r};
  assign quot  = q_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem_r  <= '0;
      dvsr_r <= divisor;
      q_r    <= dividend;
    end else if (ctl.step) begin
      rem_r <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      q_r   <= {q_r[N-2:0], ge};
    end
  end

endmodule

>>> sv/pid_controller_clamped_core.sv
// Each item passes S_MUL (16 serial multiply steps), S_DLD, S_DIV (the restoring
// divider, which retires one quotient bit per cycle), S_DNEG, S_SUM and S_DONE; a new
// sample is taken only in S_IDLE, so the core finishes one item before taking the next.
// A finished result waits in the output register while the next item is computed.
// Reset (rst_n low, synchronous): gains, setpoint and bounds to defaults,
// integral and last error to zero, no result pending.
`timescale 1ns / 1ps
module pid_controller_clamped_core import pcc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int ACC_BITS    = ACC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pcc_cfg_if.sink   cfg_bus,
  pcc_in_if.sink    in_bus,
  pcc_out_if.source out_bus
);
`include "pid_controller_clamped_core_assert.svh"

  localparam int SB   = SAMPLE_BITS;
  localparam int EW   = SB + 1;
  localparam int DW   = EW + GAIN_W;
  localparam int PW   = EW + GAIN_W + 1;
  localparam int IPW  = ACC_BITS + GAIN_W + 1;
  localparam int DPW  = EW + GAIN_W + 2;
  localparam int EPW  = EW + GAIN_W + 1;
  localparam int IW   = ((ACC_BITS > EPW) ? ACC_BITS : EPW) + 1;
  localparam int SW   = ACC_BITS + 11;
  localparam int PS   = PW - FRAC_BITS;
  localparam int IS   = IPW - FRAC_BITS;
  localparam int DS   = DW + 1 - FRAC_BITS;
  localparam int CW   = $clog2(DW + 1);
  localparam logic [CW-1:0] MUL_LAST = CW'(GAIN_W - 1);
  localparam logic [CW-1:0] DIV_LAST = CW'(DW - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DLD, S_DIV, S_DNEG, S_SUM, S_DONE
  } state_t;

  state_t                 state_r;
  logic [CW-1:0]          cnt_r;

  logic [GAIN_W-1:0]      gain_p_r, gain_i_r, gain_d_r;
  logic [SB-1:0]          setpoint_r;
  logic [DRIVE_W-1:0]     out_min_r, out_max_r;

  logic [ACC_BITS-1:0]    integral_r;
  logic [EW-1:0]          last_err_r;
  logic [EW-1:0]          err_r;
  logic [TIME_W-1:0]      elapsed_r;
  logic                   d_neg_r;
  logic [SW-1:0]          pi_r;
  logic [DS-1:0]          d_r;
  logic [SW-1:0]          sum_r;
  logic [IW-1:0]          int_sum_r;

  logic                   out_valid_r;
  logic [DRIVE_W-1:0]     out_drive_r;
  logic                   out_lo_r, out_hi_r;

  logic                   in_acc;
  logic                   out_fire;
  logic [EW-1:0]          err_in;
  logic [EW:0]            diff_in;
  logic signed [PW-1:0]   prod_p;
  logic signed [IPW-1:0]  prod_i;
  logic signed [DPW-1:0]  prod_d;
  logic signed [EPW-1:0]  prod_e;
  logic [DPW-1:0]         d_mag;
  logic [DW-1:0]          quot;
  logic [DW:0]            d_sig;
  logic                   lo_c, hi_c;
  logic                   ovf;
  logic [ACC_BITS-1:0]    integ_nxt;
  pcc_ser_ctl_t           mul_ctl, div_ctl;

  assign in_acc   = in_bus.valid && in_bus.ready;
  assign out_fire = (state_r == S_DONE) && (!out_valid_r || out_bus.ready);

  assign err_in  = {1'b0, setpoint_r} - {1'b0, in_bus.sample};
  assign diff_in = {err_in[EW-1], err_in} - {last_err_r[EW-1], last_err_r};

  assign mul_ctl.load = in_acc;
  assign mul_ctl.step = (state_r == S_MUL);
  assign div_ctl.load = (state_r == S_DLD);
  assign div_ctl.step = (state_r == S_DIV);

  pcc_ser_mul #(.W(EW)) u_mul_p (
    .clk(clk), .ctl(mul_ctl), .mcand($signed(err_in)), .mplier(gain_p_r), .prod(prod_p)
  );
  pcc_ser_mul #(.W(ACC_BITS)) u_mul_i (
    .clk(clk), .ctl(mul_ctl), .mcand($signed(integral_r)), .mplier(gain_i_r), .prod(prod_i)
  );
  pcc_ser_mul #(.W(EW + 1)) u_mul_d (
    .clk(clk), .ctl(mul_ctl), .mcand($signed(diff_in)), .mplier(gain_d_r), .prod(prod_d)
  );
  pcc_ser_mul #(.W(EW)) u_mul_e (
    .clk(clk), .ctl(mul_ctl), .mcand($signed(err_in)), .mplier(in_bus.elapsed_ms),
    .prod(prod_e)
  );

  assign d_mag = prod_d[DPW-1] ? (~prod_d + 1'b1) : prod_d;

  pcc_ser_div #(.N(DW)) u_div (
    .clk(clk), .ctl(div_ctl), .dividend(d_mag[DW-1:0]), .divisor(elapsed_r), .quot(quot)
  );

  assign d_sig = d_neg_r ? (~{1'b0, quot} + 1'b1) : {1'b0, quot};

  assign lo_c = $signed(sum_r) < $signed({{(SW-DRIVE_W){out_min_r[DRIVE_W-1]}}, out_min_r});
  assign hi_c = $signed(sum_r) > $signed({{(SW-DRIVE_W){out_max_r[DRIVE_W-1]}}, out_max_r});

  assign ovf = !((&int_sum_r[IW-1:ACC_BITS-1]) || !(|int_sum_r[IW-1:ACC_BITS-1]));
  assign integ_nxt = !ovf ? int_sum_r[ACC_BITS-1:0] :
                     (int_sum_r[IW-1] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                      : {1'b0, {(ACC_BITS-1){1'b1}}});

  assign cfg_bus.ready       = 1'b1;
  assign in_bus.ready        = (state_r == S_IDLE);
  assign out_bus.valid       = out_valid_r;
  assign out_bus.drive       = out_drive_r;
  assign out_bus.clamped_low  = out_lo_r;
  assign out_bus.clamped_high = out_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      gain_p_r    <= GAIN_P_RST;
      gain_i_r    <= GAIN_I_RST;
      gain_d_r    <= GAIN_D_RST;
      setpoint_r  <= SB'(SETPOINT_RST);
      out_min_r   <= OUT_MIN_RST;
      out_max_r   <= OUT_MAX_RST;
      integral_r  <= '0;
      last_err_r  <= '0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          REG_GAIN_P:   gain_p_r   <= cfg_bus.data;
          REG_GAIN_I:   gain_i_r   <= cfg_bus.data;
          REG_GAIN_D:   gain_d_r   <= cfg_bus.data;
          REG_SETPOINT: setpoint_r <= cfg_bus.data[SB-1:0];
          REG_OUT_MIN:  out_min_r  <= cfg_bus.data;
          REG_OUT_MAX:  out_max_r  <= cfg_bus.data;
          default: ;
        endcase
      end

      if (out_valid_r && out_bus.ready && !out_fire) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            err_r     <= err_in;
            elapsed_r <= in_bus.elapsed_ms;
            cnt_r     <= '0;
            state_r   <= S_MUL;
          end
        end
        S_MUL: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == MUL_LAST) begin
            state_r <= S_DLD;
          end
        end
        S_DLD: begin
          d_neg_r <= prod_d[DPW-1];
          pi_r    <= {{(SW-PS){prod_p[PW-1]}}, prod_p[PW-1:FRAC_BITS]}
                   + {{(SW-IS){prod_i[IPW-1]}}, prod_i[IPW-1:FRAC_BITS]};
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == DIV_LAST) begin
            state_r <= S_DNEG;
          end
        end
        S_DNEG: begin
          // no derivative term when no time has passed
          d_r       <= (elapsed_r == '0) ? '0 : d_sig[DW:FRAC_BITS];
          int_sum_r <= {{(IW-ACC_BITS){integral_r[ACC_BITS-1]}}, integral_r}
                     + {{(IW-EPW){prod_e[EPW-1]}}, prod_e};
          state_r   <= S_SUM;
        end
        S_SUM: begin
          sum_r   <= pi_r + {{(SW-DS){d_r[DS-1]}}, d_r};
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_fire) begin
            out_valid_r <= 1'b1;
            out_lo_r    <= lo_c;
            out_hi_r    <= !lo_c && hi_c;
            out_drive_r <= lo_c ? out_min_r : (hi_c ? out_max_r : sum_r[DRIVE_W-1:0]);
            integral_r  <= integ_nxt;
            last_err_r  <= err_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `PCC_ASSERT_NEVER(a_flags_excl, clk, rst_n, out_valid_r && out_lo_r && out_hi_r,
                    "both clamp flags set")
  `PCC_ASSERT(a_accept_mul, clk, rst_n, in_acc |=> (state_r == S_MUL),
              "transfer did not start multiply")
  `PCC_ASSERT(a_mul_to_div, clk, rst_n,
              (state_r == S_MUL && cnt_r == MUL_LAST) |=> (state_r == S_DLD),
              "multiply did not end after gain bits")
  `PCC_ASSERT(a_done_out, clk, rst_n, (state_r == S_DONE && !out_valid_r) |=> out_valid_r,
              "finished item not presented")

endmodule

>>> verif/pcc_checker.sv
// Scoreboard for the PID core: tracks register writes, predicts each drive transfer and checks it.
`timescale 1ns / 1ps
module pcc_checker import pcc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int ACC_BITS    = ACC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [SAMPLE_BITS-1:0]    in_sample,
  input  logic [TIME_W-1:0]         in_elapsed_ms,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [DRIVE_W-1:0] out_drive,
  input  logic                      out_clamped_low,
  input  logic                      out_clamped_high,
  output int                        fail_count,
  output int                        pending
);
  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      clamped_low;
    logic                      clamped_high;
  } drive_word_t;

  drive_word_t                 drive_expected[$];
  drive_word_t                 want;
  logic [GAIN_W-1:0]           kp, ki, kd;
  logic [SAMPLE_BITS-1:0]      target;
  logic signed [DRIVE_W-1:0]   floor_bound, ceil_bound;
  logic signed [ACC_BITS-1:0]  integ;
  logic signed [SAMPLE_BITS:0] prev_err;

  task automatic load_register(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_GAIN_P:   kp = data;
      REG_GAIN_I:   ki = data;
      REG_GAIN_D:   kd = data;
      REG_SETPOINT: target = data[SAMPLE_BITS-1:0];
      REG_OUT_MIN:  floor_bound = data;
      REG_OUT_MAX:  ceil_bound = data;
      default: ;
    endcase
  endtask

  task automatic run_pid_step(input logic [SAMPLE_BITS-1:0] smp,
                              input logic [TIME_W-1:0] dt);
    longint meas, sp, err, pe, dtl, gp, gi, gd, acc, acc_max;
    longint lo, hi, p_term, i_term, d_term, total;
    drive_word_t r;
    meas = smp;
    sp = target;
    dtl = dt;
    gp = kp;
    gi = ki;
    gd = kd;
    pe = prev_err;
    acc = integ;
    lo = floor_bound;
    hi = ceil_bound;
    acc_max = (longint'(1) <<< (ACC_BITS - 1)) - 1;
    err = sp - meas;
    // >>> on a signed 64-bit value floors; / truncates toward zero
    p_term = (err * gp) >>> FRAC_BITS;
    i_term = (acc * gi) >>> FRAC_BITS;
    d_term = 0;
    if (dtl != 0) d_term = (((err - pe) * gd) / dtl) >>> FRAC_BITS;
    total = p_term + i_term + d_term;
    r.clamped_low = 1'b0;
    r.clamped_high = 1'b0;
    if (total < lo) begin
      r.drive = floor_bound;
      r.clamped_low = 1'b1;
    end else if (total > hi) begin
      r.drive = ceil_bound;
      r.clamped_high = 1'b1;
    end else begin
      r.drive = total[DRIVE_W-1:0];
    end
    acc = acc + dtl * err;
    if (acc > acc_max) acc = acc_max;
    if (acc < -acc_max - 1) acc = -acc_max - 1;
    integ = acc[ACC_BITS-1:0];
    prev_err = err[SAMPLE_BITS:0];
    drive_expected.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      kp = GAIN_P_RST;
      ki = GAIN_I_RST;
      kd = GAIN_D_RST;
      target = SETPOINT_RST[SAMPLE_BITS-1:0];
      floor_bound = OUT_MIN_RST;
      ceil_bound = OUT_MAX_RST;
      integ = '0;
      prev_err = '0;
      fail_count = 0;
      drive_expected.delete();
    end else begin
      if (cfg_valid && cfg_ready) load_register(cfg_index, cfg_data);
      if (in_valid && in_ready) run_pid_step(in_sample, in_elapsed_ms);
      if (out_valid && out_ready) begin
        if (drive_expected.size() == 0) begin
          fail_count++;
          $error("drive transfer with no step outstanding: drive %0d", out_drive);
        end else begin
          want = drive_expected.pop_front();
          if (out_drive !== want.drive) begin
            fail_count++;
            $error("drive mismatch: expected %0d, got %0d", want.drive, out_drive);
          end
          if (out_clamped_low !== want.clamped_low) begin
            fail_count++;
            $error("clamped_low mismatch: expected %0b, got %0b",
                   want.clamped_low, out_clamped_low);
          end
          if (out_clamped_high !== want.clamped_high) begin
            fail_count++;
            $error("clamped_high mismatch: expected %0b, got %0b",
                   want.clamped_high, out_clamped_high);
          end
        end
      end
    end
    pending = drive_expected.size();
  end
endmodule

>>> verif/tb_top.sv
// Testbench top for the PID core: clock, reset, register settings, sample stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
  import pcc_pkg::*;

  localparam int SB             = SAMPLE_BITS_DEF;
  localparam int AB             = ACC_BITS_DEF;
  localparam int RAND_PHASES    = 10;
  localparam int STEPS_PER_PHASE = 45;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 64;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [GAIN_W-1:0]    UNITY_GAIN   = 16'd1 << FRAC_BITS;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum int {RX_OPEN, RX_HALF, RX_RARE_STALL, RX_MOSTLY_STALLED} rx_mode_t;

  typedef struct packed {
    logic [GAIN_W-1:0]         gain_p;
    logic [GAIN_W-1:0]         gain_i;
    logic [GAIN_W-1:0]         gain_d;
    logic [SB-1:0]             setpoint;
    logic signed [DRIVE_W-1:0] out_min;
    logic signed [DRIVE_W-1:0] out_max;
  } pid_setting_t;

  logic         clk;
  logic         rst_n;
  int           fail_count;
  int           pending;
  int           burst_left;
  int           idle_cycles;
  bit           steady;
  bit           hold_req;
  pid_setting_t cur;

  pcc_cfg_if                      cfg_bus ();
  pcc_in_if #(.SAMPLE_BITS(SB))   in_bus ();
  pcc_out_if                      out_bus ();

  pid_controller_clamped_core #(.SAMPLE_BITS(SB), .ACC_BITS(AB)) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  pcc_checker #(.SAMPLE_BITS(SB), .ACC_BITS(AB)) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_bus.valid),
    .cfg_ready        (cfg_bus.ready),
    .cfg_index        (cfg_bus.index),
    .cfg_data         (cfg_bus.data),
    .in_valid         (in_bus.valid),
    .in_ready         (in_bus.ready),
    .in_sample        (in_bus.sample),
    .in_elapsed_ms    (in_bus.elapsed_ms),
    .out_valid        (out_bus.valid),
    .out_ready        (out_bus.ready),
    .out_drive        (out_bus.drive),
    .out_clamped_low  (out_bus.clamped_low),
    .out_clamped_high (out_bus.clamped_high),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stall pattern, plus a long hold-off on request
  initial begin
    rx_mode_t mode;
    int       left;
    int       hold_left;
    mode = RX_OPEN;
    left = 0;
    hold_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          left = $urandom_range(20, 200);
        end
        left--;
        case (mode)
          RX_OPEN:       out_bus.ready <= 1'b1;
          RX_HALF:       out_bus.ready <= ($urandom_range(0, 1) == 0);
          RX_RARE_STALL: out_bus.ready <= ($urandom_range(0, 9) != 0);
          default:       out_bus.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  function automatic pid_setting_t make_setting(input logic [GAIN_W-1:0] gp,
                                                input logic [GAIN_W-1:0] gi,
                                                input logic [GAIN_W-1:0] gd,
                                                input logic [SB-1:0] sp,
                                                input logic signed [DRIVE_W-1:0] lo,
                                                input logic signed [DRIVE_W-1:0] hi);
    pid_setting_t s;
    s.gain_p = gp;
    s.gain_i = gi;
    s.gain_d = gd;
    s.setpoint = sp;
    s.out_min = lo;
    s.out_max = hi;
    return s;
  endfunction

  function automatic logic [GAIN_W-1:0] random_gain();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return UNITY_GAIN;
      3: return GAIN_W'($urandom_range(0, 1023));
      default: return GAIN_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic pid_setting_t random_setting();
    pid_setting_t s;
    logic signed [DRIVE_W-1:0] a, b;
    s.gain_p = random_gain();
    s.gain_i = random_gain();
    s.gain_d = random_gain();
    case ($urandom_range(0, 3))
      0: s.setpoint = '0;
      1: s.setpoint = '1;
      default: s.setpoint = SB'($urandom_range(0, (1 << SB) - 1));
    endcase
    a = DRIVE_W'($urandom_range(0, 65535));
    b = DRIVE_W'($urandom_range(0, 65535));
    case ($urandom_range(0, 3))
      0: begin
        s.out_min = OUT_MIN_RST;
        s.out_max = OUT_MAX_RST;
      end
      1: begin
        s.out_min = (a < b) ? a : b;
        s.out_max = (a < b) ? b : a;
      end
      2: begin
        s.out_min = (a < b) ? b : a;
        s.out_max = (a < b) ? a : b;
      end
      default: begin
        s.out_min = -DRIVE_W'($urandom_range(0, 2000));
        s.out_max = DRIVE_W'($urandom_range(0, 2000));
      end
    endcase
    return s;
  endfunction

  function automatic logic [SB-1:0] random_sample();
    int v;
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = (1 << SB) - 1;
      2: begin
        v = cur.setpoint;
        v = v + int'($urandom_range(0, 8)) - 4;
      end
      default: v = $urandom_range(0, (1 << SB) - 1);
    endcase
    if (v < 0) v = 0;
    if (v > (1 << SB) - 1) v = (1 << SB) - 1;
    return v[SB-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] random_elapsed();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: return TIME_W'($urandom_range(1, 20));
      default: return TIME_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // leaves valid high so back-to-back writes need no extra step
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= data;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  task automatic apply_setting(input pid_setting_t s, input bit with_spare);
    write_reg(REG_GAIN_P, s.gain_p);
    write_reg(REG_GAIN_I, s.gain_i);
    write_reg(REG_GAIN_D, s.gain_d);
    write_reg(REG_SETPOINT, CFG_DATA_W'(s.setpoint));
    write_reg(REG_OUT_MIN, s.out_min);
    write_reg(REG_OUT_MAX, s.out_max);
    // unmapped indexes go last so a decode alias would stick
    if (with_spare) begin
      write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom_range(0, 65535)));
      write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom_range(0, 65535)));
    end
    cfg_bus.valid <= 1'b0;
    cur = s;
  endtask

  task automatic send_sample(input logic [SB-1:0] smp, input logic [TIME_W-1:0] dt);
    int gap;
    in_bus.valid <= 1'b1;
    in_bus.sample <= smp;
    in_bus.elapsed_ms <= dt;
    do @(posedge clk); while (!in_bus.ready);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    pid_setting_t s;
    rst_n <= 1'b0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= REG_GAIN_P;
    cfg_bus.data <= '0;
    in_bus.valid <= 1'b0;
    in_bus.sample <= '0;
    in_bus.elapsed_ms <= '0;
    burst_left = 1;
    steady = 1'b0;
    hold_req = 1'b0;
    cur = make_setting(GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, SB'(SETPOINT_RST),
                       OUT_MIN_RST, OUT_MAX_RST);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: zero error, full-scale errors, zero elapsed
    send_sample(SB'(SETPOINT_RST), '0);
    send_sample('0, TIME_W'(1));
    send_sample('1, '1);
    send_sample('0, '0);
    drain();

    // all gains at max: clamp high while the integral runs into saturation
    apply_setting(make_setting('1, '1, '1, '1, OUT_MIN_RST, OUT_MAX_RST), 1'b0);
    repeat (9) send_sample('0, '1);
    send_sample('1, TIME_W'(1));
    drain();

    // inverted bounds: low bound wins when both apply
    apply_setting(make_setting(UNITY_GAIN, '0, '0, SB'(SETPOINT_RST), 16'sd100, -16'sd100),
                  1'b1);
    send_sample(SB'(SETPOINT_RST), '0);
    send_sample(SB'(SETPOINT_RST - 200), '0);
    send_sample(SB'(SETPOINT_RST + 100), '0);
    drain();

    // derivative only, negative errors, rounding of negative quotients
    apply_setting(make_setting('0, '0, 16'd300, '0, OUT_MIN_RST, OUT_MAX_RST), 1'b0);
    send_sample('0, TIME_W'(7));
    send_sample(SB'(1), TIME_W'(7));
    send_sample('1, TIME_W'(3));
    send_sample('0, '1);
    send_sample(SB'(2000), '0);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0) s = make_setting('1, '1, '1, '1, OUT_MAX_RST, OUT_MIN_RST);
      else s = random_setting();
      apply_setting(s, $urandom_range(0, 3) == 0);
      steady = ($urandom_range(0, 3) == 0);
      if (ph == 1 || ph == 6) hold_req = 1'b1;
      for (int n = 0; n < STEPS_PER_PHASE; n++) send_sample(random_sample(), random_elapsed());
      drain();
    end

    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
